### hdl/sbcs_pkg.sv
// Package for the status blink-code sequencer: transfer payload types,
// register indexes, phase codes, pattern codes and the pattern tables.
// No dependencies.
`default_nettype none

package sbcs_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned ELAPSED_W   = 17;
   localparam int unsigned COLOR_W     = 24;
   localparam int unsigned CODE_W      = 3;
   localparam int unsigned BLINKS_W    = 2;
   localparam int unsigned PHASE_W     = 2;
   localparam int unsigned DUR_W       = 16;
   localparam int unsigned COUNT_W     = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_CYCLE_GAP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_ON  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_OFF = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_REBOOT_TO = 2'd3;

   localparam logic [DUR_W-1:0]   CYCLE_GAP_RESET = 16'd3000;
   localparam logic [DUR_W-1:0]   BLINK_ON_RESET  = 16'd200;
   localparam logic [DUR_W-1:0]   BLINK_OFF_RESET = 16'd300;
   localparam logic [COUNT_W-1:0] REBOOT_TO_RESET = 32'd300000;

   localparam logic [PHASE_W-1:0] PH_GAP  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ON   = 2'd1;
   localparam logic [PHASE_W-1:0] PH_OFF  = 2'd2;
   localparam logic [PHASE_W-1:0] PH_POST = 2'd3;

   localparam logic [CODE_W-1:0] CODE_OK    = 3'd0;
   localparam logic [CODE_W-1:0] CODE_GNSS  = 3'd1;
   localparam logic [CODE_W-1:0] CODE_WIFI  = 3'd2;
   localparam logic [CODE_W-1:0] CODE_NTP   = 3'd3;
   localparam logic [CODE_W-1:0] CODE_NTRIP = 3'd4;
   localparam logic [CODE_W-1:0] CODE_MQTT  = 3'd5;

   localparam logic [COLOR_W-1:0] COLOR_FAULT = 24'hFF0000;
   localparam logic [COLOR_W-1:0] COLOR_AMBER = 24'hFFAA00;
   localparam logic [COLOR_W-1:0] COLOR_GOOD  = 24'h0000FF;
   localparam logic [COLOR_W-1:0] COLOR_DARK  = 24'h000000;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

   typedef struct packed {
      logic wifi_ok;
      logic gnss_ok;
      logic ntp_ok;
      logic mqtt_ok;
      logic ntrip_ok;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] led_color;
      logic [CODE_W-1:0]  status_code;
      logic               reboot_needed;
   } rsp_type;

   typedef struct packed {
      logic [DUR_W-1:0]   cycle_gap_ticks;
      logic [DUR_W-1:0]   blink_on_ticks;
      logic [DUR_W-1:0]   blink_off_ticks;
      logic [COUNT_W-1:0] reboot_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0]   phase;
      logic [BLINKS_W-1:0]  blinks_left;
      logic [ELAPSED_W-1:0] phase_elapsed;
      logic [CODE_W-1:0]    pattern_code;
      logic [COLOR_W-1:0]   lit_color;
      logic [COUNT_W-1:0]   since_ok;
   } state_type;

   function automatic logic [COLOR_W-1:0] pat_color(input logic [CODE_W-1:0] code);
      logic [COLOR_W-1:0] color;
      unique case (code)
         CODE_GNSS, CODE_WIFI:            color = COLOR_FAULT;
         CODE_NTP, CODE_NTRIP, CODE_MQTT: color = COLOR_AMBER;
         default:                         color = COLOR_GOOD;
      endcase
      return color;
   endfunction

   function automatic logic [BLINKS_W-1:0] pat_count(input logic [CODE_W-1:0] code);
      logic [BLINKS_W-1:0] count;
      unique case (code)
         CODE_GNSS, CODE_NTRIP: count = 2'd2;
         CODE_MQTT:             count = 2'd3;
         default:               count = 2'd1;
      endcase
      return count;
   endfunction

   function automatic logic [CODE_W-1:0] pick_pattern(input req_type flags);
      logic [CODE_W-1:0] code;
      priority if (!flags.gnss_ok)  code = CODE_GNSS;
      else if (!flags.wifi_ok)      code = CODE_WIFI;
      else if (!flags.ntp_ok)       code = CODE_NTP;
      else if (!flags.ntrip_ok)     code = CODE_NTRIP;
      else if (!flags.mqtt_ok)      code = CODE_MQTT;
      else                          code = CODE_OK;
      return code;
   endfunction

endpackage

`default_nettype wire

### hdl/status_blink_code_sequencer_unit.sv
// Top level of the status blink-code sequencer: state, registers, result register.
// Depends on sbcs_pkg and sbcs_step.
`default_nettype none

// Each req transfer is one tick with five health flags; each produces one rsp
// transfer with the LED color, the latched status code and the reboot request
// after that tick. A tick is accepted every clock cycle and its result is written
// into the result register in the cycle after; the only limit is that register,
// which accepts a new tick whenever it is empty or being read in the same cycle.
// Register writes take effect in the next cycle and are always ready.
module status_blink_code_sequencer_unit (
   input  var logic                               clock,
   input  var logic                               reset,
   input  var logic                               req_valid,
   output logic                                   req_ready,
   input  var sbcs_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  var logic                               rsp_ready,
   output sbcs_pkg::rsp_type                      rsp_data,
   input  var logic                               csr_valid,
   output logic                                   csr_ready,
   input  var logic [sbcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  var logic [sbcs_pkg::CSR_DATA_W-1:0]    csr_data
);

   sbcs_pkg::state_type state_ff, state_in;
   sbcs_pkg::cfg_type   cfg_ff, cfg_in;
   sbcs_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_fire;

   sbcs_step u_step (
      .state (state_ff),
      .cfg   (cfg_ff),
      .req   (req_data),
      .nxt   (state_in),
      .rsp   (rsp_data_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sbcs_pkg::REG_CYCLE_GAP: cfg_in.cycle_gap_ticks = csr_data[15:0];
            sbcs_pkg::REG_BLINK_ON:  cfg_in.blink_on_ticks  = csr_data[15:0];
            sbcs_pkg::REG_BLINK_OFF: cfg_in.blink_off_ticks = csr_data[15:0];
            sbcs_pkg::REG_REBOOT_TO: cfg_in.reboot_timeout_ticks = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase                 <= sbcs_pkg::PH_GAP;
         state_ff.blinks_left           <= '0;
         state_ff.phase_elapsed         <= '0;
         state_ff.pattern_code          <= sbcs_pkg::CODE_OK;
         state_ff.lit_color             <= sbcs_pkg::COLOR_DARK;
         state_ff.since_ok              <= '0;
         cfg_ff.cycle_gap_ticks         <= sbcs_pkg::CYCLE_GAP_RESET;
         cfg_ff.blink_on_ticks          <= sbcs_pkg::BLINK_ON_RESET;
         cfg_ff.blink_off_ticks         <= sbcs_pkg::BLINK_OFF_RESET;
         cfg_ff.reboot_timeout_ticks    <= sbcs_pkg::REBOOT_TO_RESET;
         rsp_valid_ff                   <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/sbcs_step.sv
// Next-state logic for one tick of the blink-code sequencer.
// Depends on sbcs_pkg.
`default_nettype none

module sbcs_step (
   input  var sbcs_pkg::state_type state,
   input  var sbcs_pkg::cfg_type   cfg,
   input  var sbcs_pkg::req_type   req,
   output sbcs_pkg::state_type     nxt,
   output sbcs_pkg::rsp_type       rsp
);

   logic [sbcs_pkg::ELAPSED_W-1:0] elapsed;
   logic [sbcs_pkg::COUNT_W-1:0]   since;
   logic [sbcs_pkg::CODE_W-1:0]    code;
   logic [sbcs_pkg::BLINKS_W-1:0]  blinks;

   always_comb begin
      since   = (state.since_ok < cfg.reboot_timeout_ticks) ?
                state.since_ok + 32'd1 : state.since_ok;
      elapsed = (state.phase_elapsed != sbcs_pkg::ELAPSED_MAX) ?
                state.phase_elapsed + 17'd1 : state.phase_elapsed;
      code    = sbcs_pkg::pick_pattern(req);
      blinks  = (state.blinks_left != 2'd0) ? state.blinks_left - 2'd1 : 2'd0;

      nxt               = state;
      nxt.phase_elapsed = elapsed;
      nxt.since_ok      = since;

      unique case (state.phase)
         sbcs_pkg::PH_GAP: begin
            if (elapsed >= {1'b0, cfg.cycle_gap_ticks}) begin
               nxt.pattern_code  = code;
               nxt.blinks_left   = sbcs_pkg::pat_count(code);
               nxt.lit_color     = sbcs_pkg::pat_color(code);
               nxt.phase         = sbcs_pkg::PH_ON;
               nxt.phase_elapsed = '0;
               if (code == sbcs_pkg::CODE_OK) begin
                  nxt.since_ok = '0;
               end
            end
         end
         sbcs_pkg::PH_ON: begin
            if (elapsed >= {1'b0, cfg.blink_on_ticks}) begin
               nxt.lit_color     = sbcs_pkg::COLOR_DARK;
               nxt.blinks_left   = blinks;
               nxt.phase         = (blinks != 2'd0) ? sbcs_pkg::PH_OFF : sbcs_pkg::PH_POST;
               nxt.phase_elapsed = '0;
            end
         end
         sbcs_pkg::PH_OFF: begin
            if (elapsed >= {1'b0, cfg.blink_off_ticks}) begin
               nxt.lit_color     = sbcs_pkg::pat_color(state.pattern_code);
               nxt.phase         = sbcs_pkg::PH_ON;
               nxt.phase_elapsed = '0;
            end
         end
         sbcs_pkg::PH_POST: begin
            if (elapsed >= {cfg.blink_off_ticks, 1'b0}) begin
               nxt.phase         = sbcs_pkg::PH_GAP;
               nxt.phase_elapsed = '0;
            end
         end
         default: begin
            nxt.phase = sbcs_pkg::PH_GAP;
         end
      endcase

      rsp.led_color     = nxt.lit_color;
      rsp.status_code   = nxt.pattern_code;
      rsp.reboot_needed = (nxt.since_ok >= cfg.reboot_timeout_ticks);
   end

endmodule

`default_nettype wire

### hdl/sbcs_checker.sv
// Port-level checks for status_blink_code_sequencer_unit, bound to the top level.
// Depends on sbcs_pkg.
`default_nettype none

module sbcs_checker (
   input var logic              clock,
   input var logic              reset,
   input var logic              req_ready,
   input var logic              rsp_valid,
   input var logic              rsp_ready,
   input var sbcs_pkg::rsp_type rsp_data
);

   hold_stalled_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with empty result register");

   code_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status_code <= sbcs_pkg::CODE_MQTT)
      else $error("status code out of range");

   color_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.led_color != sbcs_pkg::COLOR_DARK |->
         rsp_data.led_color == sbcs_pkg::pat_color(rsp_data.status_code))
      else $error("lit color does not match status code");

endmodule

bind status_blink_code_sequencer_unit sbcs_checker u_sbcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
